>>> hw/rtl/dnsa_pkg.sv
`default_nettype none
package dnsa_pkg;

    // DNS message layout
    localparam int unsigned HEADER_BYTES        = 12;
    localparam int unsigned QUESTION_TAIL_BYTES = 4;
    localparam int unsigned RECORD_FIXED_BYTES  = 12;

    // header byte offsets of the answer count
    localparam logic [3:0] POS_ANCOUNT_HI = 4'd6;
    localparam logic [3:0] POS_ANCOUNT_LO = 4'd7;

    // record field offsets
    localparam logic [3:0] FLD_TYPE_HI  = 4'd2;
    localparam logic [3:0] FLD_TYPE_LO  = 4'd3;
    localparam logic [3:0] FLD_RDLEN_HI = 4'd10;
    localparam logic [3:0] FLD_RDLEN_LO = 4'd11;
    localparam logic [3:0] FLD_END      = 4'd12;

    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [2:0]  ADDR_BYTES     = 3'd4;
    localparam logic [7:0]  QNAME_LEN_RST  = 8'd1;

    // one result request
    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  answer_index;
    } t_result;

endpackage
`default_nettype wire

>>> hw/rtl/dns_a_record_extractor_core.sv
// A result is registered when the request with an A record's last address byte
//   is accepted. A two-entry output buffer keeps input flowing while one waits.
// Throughput: one byte per cycle while o_ready is high, which holds unless both
//   entries are full; the byte parser state updates in a single pass.
// Reset (synchronous, active low) clears the parser and the output buffer and
//   sets the name length register to 1.
`default_nettype none
module dns_a_record_extractor_core #(
    parameter int unsigned MAX_PACKET_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    // results
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_address,
    output logic [7:0]       o_answer_index,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_question_name_length
);
    import dnsa_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
    localparam int unsigned AS_W = (POS_W > 9) ? POS_W : 9;

    logic [7:0]       r_qname_len;
    logic [POS_W-1:0] r_byte_pos,  n_byte_pos;
    logic [15:0]      r_ancount,   n_ancount;
    logic [15:0]      r_seen,      n_seen;
    logic [3:0]       r_fld_pos,   n_fld_pos;
    logic [15:0]      r_rtype,     n_rtype;
    logic [15:0]      r_data_rem,  n_data_rem;
    logic [2:0]       r_taken,     n_taken;
    logic [31:0]      r_addr_sh,   n_addr_sh;

    logic             produce;
    t_result          res;
    logic             in_acc;
    logic [AS_W-1:0]  answers_start;
    logic [15:0]      rem_dec;
    logic [31:0]      sh_next;

    logic             r_out_valid, r_skd_valid;
    t_result          r_out, r_skd;
    logic             pop;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_skd_valid;
    assign in_acc      = i_valid && o_ready;
    assign pop         = r_out_valid && i_ready;

    assign answers_start = AS_W'(HEADER_BYTES + QUESTION_TAIL_BYTES) + AS_W'(r_qname_len);
    assign rem_dec       = r_data_rem - 16'd1;
    assign sh_next       = {r_addr_sh[23:0], i_data_byte};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qname_len <= QNAME_LEN_RST;
        end else if (i_cfg_valid) begin
            r_qname_len <= i_cfg_question_name_length;
        end
    end

    // byte parser, one byte per pass
    always_comb begin
        n_byte_pos = r_byte_pos;
        n_ancount  = r_ancount;
        n_seen     = r_seen;
        n_fld_pos  = r_fld_pos;
        n_rtype    = r_rtype;
        n_data_rem = r_data_rem;
        n_taken    = r_taken;
        n_addr_sh  = r_addr_sh;
        produce    = 1'b0;
        res.address      = sh_next;
        res.answer_index = r_seen[7:0];

        if (r_byte_pos < POS_MAX) begin
            n_byte_pos = r_byte_pos + 1'b1;
            if (AS_W'(r_byte_pos) < answers_start) begin
                // header and question
                if (r_byte_pos == POS_W'(POS_ANCOUNT_HI)) begin
                    n_ancount = {i_data_byte, r_ancount[7:0]};
                end else if (r_byte_pos == POS_W'(POS_ANCOUNT_LO)) begin
                    n_ancount = {r_ancount[15:8], i_data_byte};
                end
            end else if (r_seen < r_ancount) begin
                if (r_fld_pos < FLD_END) begin
                    // fixed record fields
                    n_fld_pos = r_fld_pos + 4'd1;
                    case (r_fld_pos)
                        FLD_TYPE_HI:  n_rtype    = {i_data_byte, r_rtype[7:0]};
                        FLD_TYPE_LO:  n_rtype    = {r_rtype[15:8], i_data_byte};
                        FLD_RDLEN_HI: n_data_rem = {i_data_byte, r_data_rem[7:0]};
                        FLD_RDLEN_LO: begin
                            n_data_rem = {r_data_rem[15:8], i_data_byte};
                            if ({r_data_rem[15:8], i_data_byte} == 16'd0) begin
                                n_seen     = r_seen + 16'd1;
                                n_fld_pos  = '0;
                                n_rtype    = '0;
                                n_data_rem = '0;
                                n_taken    = '0;
                                n_addr_sh  = '0;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    // record data
                    n_data_rem = rem_dec;
                    if (r_rtype == TYPE_A && r_taken < ADDR_BYTES) begin
                        n_addr_sh = sh_next;
                        n_taken   = r_taken + 3'd1;
                        produce   = (r_taken + 3'd1) == ADDR_BYTES;
                    end
                    if (rem_dec == 16'd0) begin
                        n_seen     = r_seen + 16'd1;
                        n_fld_pos  = '0;
                        n_rtype    = '0;
                        n_data_rem = '0;
                        n_taken    = '0;
                        n_addr_sh  = '0;
                    end
                end
            end
        end

        // end of packet clears the parser
        if (i_last) begin
            n_byte_pos = '0;
            n_ancount  = '0;
            n_seen     = '0;
            n_fld_pos  = '0;
            n_rtype    = '0;
            n_data_rem = '0;
            n_taken    = '0;
            n_addr_sh  = '0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_ancount  <= '0;
            r_seen     <= '0;
            r_fld_pos  <= '0;
            r_rtype    <= '0;
            r_data_rem <= '0;
            r_taken    <= '0;
            r_addr_sh  <= '0;
        end else if (in_acc) begin
            r_byte_pos <= n_byte_pos;
            r_ancount  <= n_ancount;
            r_seen     <= n_seen;
            r_fld_pos  <= n_fld_pos;
            r_rtype    <= n_rtype;
            r_data_rem <= n_data_rem;
            r_taken    <= n_taken;
            r_addr_sh  <= n_addr_sh;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skd_valid) begin
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc && produce;
                end
            end else if (in_acc && produce) begin
                if (r_out_valid) begin
                    r_skd_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skd_valid ? r_skd : res;
        end else if (in_acc && produce) begin
            if (r_out_valid) begin
                r_skd <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_address      = r_out.address;
    assign o_answer_index = r_out.answer_index;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry holds a result while output register is empty");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos <= POS_MAX)
        else $error("byte position passed the packet size limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> (r_byte_pos == '0 && r_seen == '0 && r_taken == '0))
        else $error("parser not cleared after last byte");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= ADDR_BYTES && r_fld_pos <= FLD_END)
        else $error("record counters out of range");

    a_produce_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && produce) |-> (r_rtype == TYPE_A && r_taken == ADDR_BYTES - 3'd1))
        else $error("result raised without a full A record address");

endmodule
`default_nettype wire

>>> tb/sv/dnsa_result_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dnsa_result_checker #(
    parameter int unsigned MAX_PACKET_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    // results
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [31:0] i_address,
    input  wire logic [7:0]  i_answer_index,
    // configuration
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_qname_len,
    output int               o_fail_count,
    output int               o_outstanding
);
    import dnsa_pkg::*;

    // shadow of the parser state
    logic [7:0]  qname_len;
    int unsigned byte_pos;
    logic [15:0] ans_count;
    logic [15:0] ans_seen;
    logic [3:0]  fld_pos;
    logic [15:0] rec_type;
    logic [15:0] data_rem;
    logic [2:0]  addr_taken;
    logic [31:0] addr_shift;

    t_result     expected_addrs[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    initial o_outstanding = 0;

    // step past the current answer record
    task automatic close_record();
        ans_seen   = ans_seen + 16'd1;
        fld_pos    = '0;
        rec_type   = '0;
        data_rem   = '0;
        addr_taken = '0;
        addr_shift = '0;
    endtask

    task automatic clear_parse();
        byte_pos   = 0;
        ans_count  = '0;
        ans_seen   = '0;
        fld_pos    = '0;
        rec_type   = '0;
        data_rem   = '0;
        addr_taken = '0;
        addr_shift = '0;
    endtask

    // one accepted byte; queues the address when an A record's fourth data byte lands
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        int unsigned ans_start;
        int unsigned pos;
        logic [3:0]  fld;
        t_result     hit;
        ans_start = HEADER_BYTES + qname_len + QUESTION_TAIL_BYTES;
        if (byte_pos < MAX_PACKET_BYTES) begin
            pos = byte_pos;
            byte_pos++;
            if (pos < ans_start) begin
                if (pos == POS_ANCOUNT_HI) begin
                    ans_count[15:8] = b;
                end else if (pos == POS_ANCOUNT_LO) begin
                    ans_count[7:0] = b;
                end
            end else if (ans_seen < ans_count) begin
                if (fld_pos < FLD_END) begin
                    fld     = fld_pos;
                    fld_pos = fld_pos + 4'd1;
                    case (fld)
                        FLD_TYPE_HI:  rec_type[15:8] = b;
                        FLD_TYPE_LO:  rec_type[7:0]  = b;
                        FLD_RDLEN_HI: data_rem[15:8] = b;
                        FLD_RDLEN_LO: begin
                            data_rem[7:0] = b;
                            if (data_rem == 16'd0) close_record();
                        end
                        default: ;
                    endcase
                end else begin
                    data_rem = data_rem - 16'd1;
                    if (rec_type == TYPE_A && addr_taken < ADDR_BYTES) begin
                        addr_shift = {addr_shift[23:0], b};
                        addr_taken = addr_taken + 3'd1;
                        if (addr_taken == ADDR_BYTES) begin
                            hit.address      = addr_shift;
                            hit.answer_index = ans_seen[7:0];
                            expected_addrs.insert(expected_addrs.size(), hit);
                        end
                    end
                    if (data_rem == 16'd0) close_record();
                end
            end
        end
        if (lst) clear_parse();
    endtask

    // compare results first: each one comes from a byte taken on an earlier edge
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            qname_len = QNAME_LEN_RST;
            clear_parse();
            expected_addrs.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_addrs.size() == 0) begin
                    $error("unexpected result: address %h answer_index %0d",
                           i_address, i_answer_index);
                    fail_count++;
                end else begin
                    want = expected_addrs.pop_front();
                    if (i_address !== want.address) begin
                        $error("address: expected %h, got %h", want.address, i_address);
                        fail_count++;
                    end
                    if (i_answer_index !== want.answer_index) begin
                        $error("answer_index: expected %0d, got %0d",
                               want.answer_index, i_answer_index);
                        fail_count++;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) parse_byte(i_data_byte, i_last);
            if (i_cfg_valid && i_cfg_ready) qname_len = i_cfg_qname_len;
        end
        o_outstanding <= expected_addrs.size();
    end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import dnsa_pkg::*;

    localparam int unsigned PKT_LIMIT   = 512;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASE_BYTES = 270;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = '0;
    logic        byte_last    = 1'b0;
    logic        res_valid;
    logic        res_ready    = 1'b0;
    logic [31:0] address;
    logic [7:0]  answer_index;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_qname_len = '0;

    int          fail_count;
    int          outstanding;
    int          cycles       = 0;
    int          ready_left   = 0;
    int          sent_bytes   = 0;

    // packet under construction and the name length it is built for
    logic [7:0]  pkt_bytes[$];
    logic [7:0]  qname_len    = QNAME_LEN_RST;

    always #6 clk = ~clk;

    dns_a_record_extractor_core #(
        .MAX_PACKET_BYTES(PKT_LIMIT)
    ) dut (
        .i_clk                      (clk),
        .i_rst_n                    (rst_n),
        .i_valid                    (in_valid),
        .o_ready                    (in_ready),
        .i_data_byte                (data_byte),
        .i_last                     (byte_last),
        .o_valid                    (res_valid),
        .i_ready                    (res_ready),
        .o_address                  (address),
        .o_answer_index             (answer_index),
        .i_cfg_valid                (cfg_valid),
        .o_cfg_ready                (cfg_ready),
        .i_cfg_question_name_length (cfg_qname_len)
    );

    dnsa_result_checker #(
        .MAX_PACKET_BYTES(PKT_LIMIT)
    ) result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_byte_valid    (in_valid),
        .i_byte_ready    (in_ready),
        .i_data_byte     (data_byte),
        .i_last          (byte_last),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_address       (address),
        .i_answer_index  (answer_index),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_qname_len (cfg_qname_len),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("dns_a_record_extractor_core test failed");
            $finish;
        end
    end

    // result side back-pressure: long ready runs, short stalls, rare long stalls
    always @(posedge clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    res_ready  <= 1'b1;
                    ready_left <= $urandom_range(0, 30);
                end
                9: begin
                    res_ready  <= 1'b0;
                    ready_left <= $urandom_range(5, 40);
                end
                default: begin
                    res_ready  <= 1'b0;
                    ready_left <= $urandom_range(0, 2);
                end
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one byte request; valid stays up between back-to-back requests
    task automatic send_byte(input logic [7:0] b, input logic lst, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        byte_last <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_packet();
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < pkt_bytes.size(); k++) begin
            send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1, burst);
        end
    endtask

    // drop valid and let every pending result drain out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_qname_len(input logic [7:0] v);
        wait_drained();
        cfg_valid     <= 1'b1;
        cfg_qname_len <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        qname_len = v;
    endtask

    // append one byte to the packet under construction
    task automatic append_byte(input logic [7:0] v);
        pkt_bytes.insert(pkt_bytes.size(), v);
    endtask

    task automatic add_random(input int n);
        repeat (n) append_byte(8'($urandom));
    endtask

    task automatic add_be16(input logic [15:0] v);
        append_byte(v[15:8]);
        append_byte(v[7:0]);
    endtask

    // header with the answer count, then a question of random content
    task automatic start_packet(input logic [15:0] an_count);
        pkt_bytes.delete();
        add_random(12);
        pkt_bytes[POS_ANCOUNT_HI] = an_count[15:8];
        pkt_bytes[POS_ANCOUNT_LO] = an_count[7:0];
        add_random(int'(qname_len) + QUESTION_TAIL_BYTES);
    endtask

    // fill < 0 gives random data, else every data byte is fill
    task automatic add_record(input logic [15:0] rtype, input logic [15:0] rdlen,
                              input int n_data, input int fill);
        if ($urandom_range(0, 1)) add_be16(16'hC00C);
        else add_random(2);
        add_be16(rtype);
        add_random(6);
        add_be16(rdlen);
        repeat (n_data) append_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    task automatic add_random_record();
        int          r;
        int          k;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            rtype = TYPE_A;
            k     = $urandom_range(0, 19);
            if (k < 14) rdlen = 16'd4;
            else if (k < 17) rdlen = 16'($urandom_range(0, 3));
            else rdlen = 16'($urandom_range(5, 20));
        end else if (r < 75) begin
            rtype = 16'd28;
            rdlen = 16'd16;
        end else if (r < 85) begin
            // low byte matches an A record, high byte does not
            rtype = {8'($urandom_range(1, 255)), 8'h01};
            rdlen = 16'd4;
        end else begin
            rtype = 16'($urandom);
            rdlen = 16'($urandom_range(0, 20));
        end
        if ($urandom_range(0, 49) == 0) rdlen = 16'($urandom_range(21, 65535));
        add_record(rtype, rdlen, rdlen > 40 ? $urandom_range(0, 40) : int'(rdlen), -1);
    endtask

    // mostly well-formed responses, plus count mismatches, cuts and noise
    task automatic build_random_packet();
        int          r;
        int          n;
        int          cut;
        logic [15:0] an;
        r = $urandom_range(0, 99);
        n = $urandom_range(1, 4);
        if (r >= 94) begin
            pkt_bytes.delete();
            add_random($urandom_range(1, 60));
            return;
        end
        if (r < 60) an = 16'(n);
        else if (r < 70) an = 16'(n + $urandom_range(1, 3));
        else if (r < 80) an = 16'($urandom_range(0, n - 1));
        else if (r < 88) an = 16'(n);
        else an = 16'($urandom_range(256, 65535));
        start_packet(an);
        repeat (n) add_random_record();
        if ((r >= 80 && r < 88) || (r >= 60 && r < 70 && $urandom_range(0, 1))) begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end else if ($urandom_range(0, 3) == 0) begin
            add_random($urandom_range(1, 6));
        end
    endtask

    // stimulus and verdict
    initial begin : stim
        logic [7:0] phase_len[6];
        int         phase_start;
        bit         first;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short A record, all-ones and all-zero addresses, bytes after
        // the counted answers, then a one-byte packet
        start_packet(16'd3);
        add_record(TYPE_A, 16'd2, 2, -1);
        add_record(TYPE_A, 16'd4, 4, 8'hFF);
        add_record(TYPE_A, 16'd4, 4, 8'h00);
        add_random(2);
        send_packet();
        pkt_bytes.delete();
        append_byte(8'hFF);
        send_packet();

        // name length settings: both extremes, the reset value and random ones
        phase_len[0] = 8'd0;
        phase_len[1] = 8'd255;
        phase_len[2] = 8'($urandom_range(2, 40));
        phase_len[3] = QNAME_LEN_RST;
        phase_len[4] = 8'($urandom_range(1, 255));
        phase_len[5] = 8'($urandom_range(1, 20));
        for (int p = 0; p < 6; p++) begin
            write_qname_len(phase_len[p]);
            phase_start = sent_bytes;
            first       = 1'b1;
            while (sent_bytes - phase_start < PHASE_BYTES) begin
                if (p == 3 && first) begin
                    // runs past the packet size limit
                    start_packet(16'hFFFF);
                    while (pkt_bytes.size() < PKT_LIMIT + 48) add_random_record();
                end else begin
                    build_random_packet();
                end
                send_packet();
                first = 1'b0;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("dns_a_record_extractor_core test passed");
        end else begin
            $display("dns_a_record_extractor_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/dnsa_pkg.sv
hw/rtl/dns_a_record_extractor_core.sv
tb/sv/dnsa_result_checker.sv
tb/sv/tb.sv
